// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- design/tlik_pkg.sv -----
// Types, constants and the arctangent table of the leg inverse kinematics unit.
package tlik_pkg;

    localparam int SQRT_STEPS = 28;
    localparam int TABLE_LEN  = 24;
    localparam logic [22:0] DEG90_FINE = 23'd5898240;

    typedef struct packed {
        logic [31:0] rem;
        logic [27:0] root;
        logic [23:0] rad;
    } t_sq_lane;

    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [24:0] z;
    } t_vec;

    typedef struct packed {
        logic origin;
        logic far;
        logic unreach;
        logic x_zero;
        logic y_zero;
    } t_flags;

    function automatic logic [21:0] f_atan(input int idx);
        logic [21:0] v;
        unique case (idx)
            0:  v = 22'd2949120;
            1:  v = 22'd1740967;
            2:  v = 22'd919879;
            3:  v = 22'd466945;
            4:  v = 22'd234379;
            5:  v = 22'd117304;
            6:  v = 22'd58666;
            7:  v = 22'd29335;
            8:  v = 22'd14668;
            9:  v = 22'd7334;
            10: v = 22'd3667;
            11: v = 22'd1833;
            12: v = 22'd917;
            13: v = 22'd458;
            14: v = 22'd229;
            15: v = 22'd115;
            16: v = 22'd57;
            17: v = 22'd29;
            18: v = 22'd14;
            19: v = 22'd7;
            20: v = 22'd4;
            21: v = 22'd2;
            22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/two_link_leg_inverse_kinematics_unit.sv -----
// Top level of the two-link leg inverse kinematics unit.
//
// Targets arrive on the s_axis channel: tdata holds target_x in bits 10:0
// and target_y in bits 21:11, in 1/32 mm. Results leave on the m_axis
// channel: tdata holds hip_angle in bits 15:0 and knee_angle in bits 31:16,
// both in 1/256 degree, and tuser bit 0 is the unreachable flag.
// The link length in mm is written on the cfg channel, which is always
// ready; it may only change while no target is in flight.
// The datapath is a chain of cells: one entry stage forms the squares of
// the target and the reach, 28 square root digit cells follow, then one
// CORDIC cell per iteration, then the output register. One target is
// accepted every cycle while the chain is not stalled.
// The whole chain advances together; while the output holds a result the
// receiver has not taken, the chain and the input stall.
// Reset empties the chain and sets the link length to 40 mm.
module two_link_leg_inverse_kinematics_unit #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // target_x, target_y, zero pad
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // hip_angle, knee_angle
    output logic [0:0]  o_m_axis_tuser,  // unreachable
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data
);

    localparam int NS = tlik_pkg::SQRT_STEPS;

    logic        w_en;
    logic [5:0]  r_link_len;

    logic        r_a_valid;
    logic [10:0] r_a_x;
    logic [10:0] r_a_y;
    logic [21:0] r_a_xx;
    logic [21:0] r_a_yy;
    logic [21:0] r_a_d2;

    logic [22:0] w_r2;
    logic        w_far;

    logic               sq_valid [0:NS];
    tlik_pkg::t_sq_lane sq_r     [0:NS];
    tlik_pkg::t_sq_lane sq_h     [0:NS];
    logic [10:0]        sq_x     [0:NS];
    logic [10:0]        sq_y     [0:NS];
    tlik_pkg::t_flags   sq_flags [0:NS];

    logic             cv_valid [0:ANGLE_ITERATIONS];
    tlik_pkg::t_vec   cv_phi   [0:ANGLE_ITERATIONS];
    tlik_pkg::t_vec   cv_half  [0:ANGLE_ITERATIONS];
    tlik_pkg::t_flags cv_flags [0:ANGLE_ITERATIONS];

    tlik_pkg::t_flags   w_fl;
    logic [22:0]        w_phi;
    logic [22:0]        w_half;
    logic signed [24:0] w_hip_s;
    logic [24:0]        w_knee_s;

    logic        r_out_valid;
    logic [15:0] r_hip;
    logic [15:0] r_knee;
    logic        r_unreach;

    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_len <= 6'd40;
        end else if (i_cfg_valid) begin
            r_link_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_x  <= i_s_axis_tdata[10:0];
            r_a_y  <= i_s_axis_tdata[21:11];
            r_a_xx <= i_s_axis_tdata[10:0] * i_s_axis_tdata[10:0];
            r_a_yy <= i_s_axis_tdata[21:11] * i_s_axis_tdata[21:11];
            r_a_d2 <= {4'(r_link_len * r_link_len) == 4'd0 && r_link_len == 6'd0 ?
                       12'd0 : 12'(r_link_len * r_link_len), 10'd0};
        end
    end

    assign w_r2  = {1'b0, r_a_xx} + {1'b0, r_a_yy};
    assign w_far = (w_r2 >= {1'b0, r_a_d2});

    always_comb begin
        sq_valid[0]          = r_a_valid;
        sq_x[0]              = r_a_x;
        sq_y[0]              = r_a_y;
        sq_flags[0].origin   = (w_r2 == 23'd0);
        sq_flags[0].far      = w_far;
        sq_flags[0].unreach  = (w_r2 == 23'd0) || (w_r2 > {1'b0, r_a_d2});
        sq_flags[0].x_zero   = (r_a_x == 11'd0);
        sq_flags[0].y_zero   = (r_a_y == 11'd0);
        sq_r[0].rem          = 32'd0;
        sq_r[0].root         = 28'd0;
        sq_r[0].rad          = {1'b0, w_r2};
        sq_h[0].rem          = 32'd0;
        sq_h[0].root         = 28'd0;
        sq_h[0].rad          = w_far ? 24'd0 : 24'({1'b0, r_a_d2} - w_r2);
    end

    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        tlik_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (sq_valid[k]),
            .i_r     (sq_r[k]),
            .i_h     (sq_h[k]),
            .i_x     (sq_x[k]),
            .i_y     (sq_y[k]),
            .i_flags (sq_flags[k]),
            .o_valid (sq_valid[k+1]),
            .o_r     (sq_r[k+1]),
            .o_h     (sq_h[k+1]),
            .o_x     (sq_x[k+1]),
            .o_y     (sq_y[k+1]),
            .o_flags (sq_flags[k+1])
        );
    end

    always_comb begin
        cv_valid[0]   = sq_valid[NS];
        cv_flags[0]   = sq_flags[NS];
        cv_phi[0].vx  = {5'd0, sq_x[NS], 16'd0};
        cv_phi[0].vy  = {5'd0, sq_y[NS], 16'd0};
        cv_phi[0].z   = 25'sd0;
        cv_half[0].vx = {4'd0, sq_r[NS].root};
        cv_half[0].vy = {4'd0, sq_h[NS].root};
        cv_half[0].z  = 25'sd0;
    end

    for (genvar k = 0; k < ANGLE_ITERATIONS; k++) begin : g_cordic
        tlik_cordic_cell #(.STAGE(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (cv_valid[k]),
            .i_phi   (cv_phi[k]),
            .i_half  (cv_half[k]),
            .i_flags (cv_flags[k]),
            .o_valid (cv_valid[k+1]),
            .o_phi   (cv_phi[k+1]),
            .o_half  (cv_half[k+1]),
            .o_flags (cv_flags[k+1])
        );
    end

    function automatic logic [22:0] f_clamp(input logic signed [24:0] z);
        logic [22:0] v;
        if (z < 0) begin
            v = 23'd0;
        end else if (z > $signed({2'b00, tlik_pkg::DEG90_FINE})) begin
            v = tlik_pkg::DEG90_FINE;
        end else begin
            v = z[22:0];
        end
        return v;
    endfunction

    always_comb begin
        w_fl = cv_flags[ANGLE_ITERATIONS];
        priority if (w_fl.y_zero) begin
            w_phi = 23'd0;
        end else if (w_fl.x_zero) begin
            w_phi = tlik_pkg::DEG90_FINE;
        end else begin
            w_phi = f_clamp(cv_phi[ANGLE_ITERATIONS].z);
        end
        priority if (w_fl.origin) begin
            w_half = tlik_pkg::DEG90_FINE;
        end else if (w_fl.far) begin
            w_half = 23'd0;
        end else begin
            w_half = f_clamp(cv_half[ANGLE_ITERATIONS].z);
        end
        w_hip_s  = $signed({2'b00, w_phi}) - $signed({2'b00, w_half}) + 25'sd128;
        w_knee_s = {1'b0, w_half, 1'b0} + 25'd128;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= cv_valid[ANGLE_ITERATIONS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hip     <= w_hip_s[23:8];
            r_knee    <= w_knee_s[23:8];
            r_unreach <= w_fl.unreach;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = {r_knee, r_hip};
    assign o_m_axis_tuser[0] = r_unreach;

    `include "assert_macros.svh"

    `ASSERT_IMPL(a_knee_range, i_clk, i_rst_n, r_out_valid, r_knee <= 16'd46080, "knee out of range")
    `ASSERT_IMPL(a_unreach_sat, i_clk, i_rst_n, r_out_valid && r_unreach, r_knee == 16'd0 || r_knee == 16'd46080, "unreachable knee not saturated")
    `ASSERT_IMPL(a_stall_hold, i_clk, i_rst_n, r_out_valid && !i_m_axis_tready, !o_s_axis_tready, "input taken during stall")
    `ASSERT_PROP(a_chain_freeze, i_clk, i_rst_n, !w_en |=> $stable(cv_valid[ANGLE_ITERATIONS]), "chain moved during stall")

endmodule

// ----- design/tlik_sqrt_cell.sv -----
// One digit cell of the pipelined square root, two lanes, carrying the target along.
module tlik_sqrt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  tlik_pkg::t_sq_lane i_r,
    input  tlik_pkg::t_sq_lane i_h,
    input  logic [10:0]       i_x,
    input  logic [10:0]       i_y,
    input  tlik_pkg::t_flags  i_flags,
    output logic              o_valid,
    output tlik_pkg::t_sq_lane o_r,
    output tlik_pkg::t_sq_lane o_h,
    output logic [10:0]       o_x,
    output logic [10:0]       o_y,
    output tlik_pkg::t_flags  o_flags
);

    tlik_pkg::t_sq_lane n_r;
    tlik_pkg::t_sq_lane n_h;
    logic               r_valid;
    tlik_pkg::t_sq_lane r_r;
    tlik_pkg::t_sq_lane r_h;
    logic [10:0]        r_x;
    logic [10:0]        r_y;
    tlik_pkg::t_flags   r_flags;

    function automatic tlik_pkg::t_sq_lane f_step(input tlik_pkg::t_sq_lane a);
        tlik_pkg::t_sq_lane b;
        logic [31:0] rem_s;
        logic [31:0] trial;
        logic        ge;
        rem_s  = {a.rem[29:0], a.rad[23:22]};
        trial  = {2'b00, a.root, 2'b01};
        ge     = (rem_s >= trial);
        b.rem  = ge ? (rem_s - trial) : rem_s;
        b.root = {a.root[26:0], ge};
        b.rad  = {a.rad[21:0], 2'b00};
        return b;
    endfunction

    always_comb begin
        n_r = f_step(i_r);
        n_h = f_step(i_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r     <= n_r;
            r_h     <= n_h;
            r_x     <= i_x;
            r_y     <= i_y;
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_r     = r_r;
    assign o_h     = r_h;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_flags = r_flags;

endmodule

// ----- design/tlik_cordic_cell.sv -----
// One vectoring CORDIC iteration for the foot direction and the half knee angle.
module tlik_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  tlik_pkg::t_vec   i_phi,
    input  tlik_pkg::t_vec   i_half,
    input  tlik_pkg::t_flags i_flags,
    output logic             o_valid,
    output tlik_pkg::t_vec   o_phi,
    output tlik_pkg::t_vec   o_half,
    output tlik_pkg::t_flags o_flags
);

    localparam logic signed [24:0] ATAN = 25'(tlik_pkg::f_atan(STAGE));

    tlik_pkg::t_vec   n_phi;
    tlik_pkg::t_vec   n_half;
    logic             r_valid;
    tlik_pkg::t_vec   r_phi;
    tlik_pkg::t_vec   r_half;
    tlik_pkg::t_flags r_flags;

    function automatic tlik_pkg::t_vec f_rot(input tlik_pkg::t_vec a);
        tlik_pkg::t_vec     b;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        tx = $signed(a.vx) >>> STAGE;
        ty = $signed(a.vy) >>> STAGE;
        if (a.vy >= 0) begin
            b.vx = a.vx + ty;
            b.vy = a.vy - tx;
            b.z  = a.z + ATAN;
        end else begin
            b.vx = a.vx - ty;
            b.vy = a.vy + tx;
            b.z  = a.z - ATAN;
        end
        return b;
    endfunction

    always_comb begin
        n_phi  = f_rot(i_phi);
        n_half = f_rot(i_half);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_phi   <= n_phi;
            r_half  <= n_half;
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_phi   = r_phi;
    assign o_half  = r_half;
    assign o_flags = r_flags;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench of the two-link leg inverse kinematics unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITERS = 16;
    localparam int LATENCY = 30 + ITERS;
    localparam int WATCHDOG = 20000;
    localparam int HOLD_CYCLES = 200;
    localparam longint QUARTER_TURN = 90 * 65536;

    typedef struct packed {
        logic [15:0] hip;
        logic [15:0] knee;
        logic        unreach;
    } t_angles;

    typedef struct {
        logic [10:0] x;
        logic [10:0] y;
        logic        known;
        t_angles     ang;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;
    logic [0:0]  o_m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [5:0]  i_cfg_data;

    two_link_leg_inverse_kinematics_unit #(.ANGLE_ITERATIONS(ITERS)) DUT (.*);

    longint  arctan_fine [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
        58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2,
        1, 0};
    logic [5:0] link_mm;
    t_angles    angles_due [$];
    int         mismatches;
    int         idle_cycles;
    int         hold_left;
    bit         timed_out;
    bit         hold_off;
    bit         hold_done;
    bit         stim_done;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint vector_angle(longint adj, longint opp);
        longint vx;
        longint vy;
        longint z;
        longint tx;
        longint ty;
        vx = adj;
        vy = opp;
        z = 0;
        if (opp == 0) return 0;
        if (adj == 0) return QUARTER_TURN;
        for (int i = 0; i < ITERS && i < 24; i++) begin
            tx = shr_floor(vx, i);
            ty = shr_floor(vy, i);
            if (vy >= 0) begin
                vx += ty;
                vy -= tx;
                z += arctan_fine[i];
            end else begin
                vx -= ty;
                vy += tx;
                z -= arctan_fine[i];
            end
        end
        if (z < 0) z = 0;
        if (z > QUARTER_TURN) z = QUARTER_TURN;
        return z;
    endfunction

    function automatic t_angles solve_leg(logic [10:0] x, logic [10:0] y, logic [5:0] len);
        longint r2;
        longint d2;
        longint phi;
        longint half;
        t_angles a;
        r2 = longint'(x) * x + longint'(y) * y;
        d2 = (longint'(len) * 32) ** 2;
        phi = vector_angle(longint'(x) << 16, longint'(y) << 16);
        if (r2 == 0) begin
            half = QUARTER_TURN;
            a.unreach = 1'b1;
        end else if (r2 >= d2) begin
            half = 0;
            a.unreach = (r2 > d2);
        end else begin
            half = vector_angle(int_sqrt(r2 << 32), int_sqrt((d2 - r2) << 32));
            a.unreach = 1'b0;
        end
        a.knee = 16'(shr_floor(2 * half + 128, 8));
        a.hip = 16'(shr_floor(phi - half + 128, 8));
        return a;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    task automatic write_link(logic [5:0] len);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        link_mm = len;
    endtask

    task automatic send_target(t_row row, bit steady);
        t_angles want;
        int gap;
        gap = steady ? 0 : gap_len();
        if (!steady && $urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        want = solve_leg(row.x, row.y, link_mm);
        if (row.known && want != row.ang) begin
            $display("table row (%0d,%0d) disagrees with prediction", row.x, row.y);
            mismatches++;
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {2'b0, row.y, row.x};
        do @(posedge i_clk); while (!o_s_axis_tready);
        angles_due.push_back(want);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (angles_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    function automatic t_row mk(int x, int y, bit known = 0, int hip = 0, int knee = 0,
                                bit unr = 0);
        t_row r;
        r.x = 11'(x);
        r.y = 11'(y);
        r.known = known;
        r.ang = '{hip: 16'(hip), knee: 16'(knee), unreach: unr};
        return r;
    endfunction

    // Receiver with random stalls, plus one long hold-off counted here once requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_off && !hold_done) begin
            i_m_axis_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 9) < 7);
        end
    end

    always @(posedge i_clk) begin
        t_angles got;
        t_angles want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = {o_m_axis_tdata[15:0], o_m_axis_tdata[31:16], o_m_axis_tuser[0]};
            if (angles_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = angles_due.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: hip %0d/%0d knee %0d/%0d unreach %0d/%0d",
                            $signed(want.hip), $signed(got.hip), want.knee, got.knee,
                            want.unreach, got.unreach);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG && !timed_out) begin
            timed_out = 1'b1;
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_row rows [$];
        logic [5:0] lengths [6] = '{6'd40, 6'd1, 6'd63, 6'd0, 6'd17, 6'd40};
        int lim;
        int x;
        int y;
        mismatches = 0;
        timed_out = 0;
        hold_off = 0;
        stim_done = 0;
        link_mm = 6'd40;
        i_rst_n <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows at the reset link length of 40 mm (reach 1280).
        rows = '{mk(0, 0, 1, -23040, 46080, 1), mk(2047, 0, 1, 0, 0, 1),
                 mk(0, 2047, 1, 23040, 0, 1), mk(2047, 2047), mk(1280, 0, 1, 0, 0, 0),
                 mk(0, 1280, 1, 23040, 0, 0), mk(1, 0), mk(0, 1), mk(1, 1), mk(1279, 0),
                 mk(905, 905), mk(800, 600), mk(600, 800), mk(1024, 1), mk(1, 1024),
                 mk(1365, 682), mk(682, 1365), mk(300, 200)};
        foreach (rows[i]) send_target(rows[i], 0);
        drain();

        foreach (lengths[p]) begin
            write_link(lengths[p]);
            lim = (lengths[p] == 0) ? 2047 : lengths[p] * 32 + 32;
            if (lim > 2047) lim = 2047;
            for (int n = 0; n < 80; n++) begin
                case ($urandom_range(0, 5))
                    0: begin
                        x = $urandom_range(0, 2047);
                        y = $urandom_range(0, 2047);
                    end
                    1: begin
                        x = $urandom_range(0, 1) ? 0 : $urandom_range(0, lim);
                        y = (x == 0) ? $urandom_range(0, lim) : 0;
                    end
                    default: begin
                        x = $urandom_range(0, lim);
                        y = $urandom_range(0, lim);
                    end
                endcase
                if (p == 1 && n == 20) begin
                    hold_off = 1'b1;
                    for (int k = 0; k < LATENCY + 20; k++) send_target(mk(x + k % 2, y), 1);
                end
                send_target(mk(x, y), (n % 30) >= 25);
            end
            drain();
        end

        stim_done = 1'b1;
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        while (!stim_done) @(posedge i_clk);
    end
endmodule
